>>> rtl/core/point_in_polygon_blob_finder_defines.svh
// Assertion macros shared by the point-in-polygon checker.
`ifndef POINT_IN_POLYGON_BLOB_FINDER_DEFINES_SVH
`define POINT_IN_POLYGON_BLOB_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pip_pkg.sv
// Shared constants, types and state codes of the point-in-polygon blob finder.
package pip_pkg;

  localparam int MAX_BLOBS  = 8;
  localparam int MAX_VERTS  = 256;
  localparam int COORD_BITS = 16;

  localparam int BLOB_IDX_BITS = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
  localparam int BLOB_CNT_BITS = $clog2(MAX_BLOBS + 1);
  localparam int VERT_BITS     = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CNT_BITS      = $clog2(MAX_VERTS + 1);
  localparam int VTX_DEPTH     = MAX_BLOBS * MAX_VERTS;
  localparam int ADDR_BITS     = $clog2(VTX_DEPTH);
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = 2 * DIFF_BITS;

  localparam int CFG_BITS       = 4;
  localparam int SLOT_BLOB_BITS = 3;
  localparam int SLOT_VERT_BITS = 8;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_PRIME,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } pip_state_e;

  // Control from the sequencer to the edge pipeline.
  typedef struct packed {
    logic data_valid;
    logic prime;
    logic clear;
  } pip_edge_ctl_t;

  // Status from the edge pipeline back to the sequencer.
  typedef struct packed {
    logic busy;
    logic hit;
  } pip_edge_sts_t;

endpackage

>>> rtl/core/pip_if.sv
// Valid/ready channel interfaces for query/load items and results.
interface pip_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic [pip_pkg::SLOT_BLOB_BITS-1:0]   blob_slot;
  logic [pip_pkg::SLOT_VERT_BITS-1:0]   vertex_slot;
  logic                                 last_vertex;
  logic signed [pip_pkg::COORD_BITS-1:0] coord_x;
  logic signed [pip_pkg::COORD_BITS-1:0] coord_y;

  modport source (output valid, kind, blob_slot, vertex_slot, last_vertex, coord_x, coord_y,
                  input ready);
  modport sink   (input valid, kind, blob_slot, vertex_slot, last_vertex, coord_x, coord_y,
                  output ready);
endinterface

interface pip_out_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic [pip_pkg::SLOT_BLOB_BITS-1:0] blob_index;

  modport source (output valid, found, blob_index, input ready);
  modport sink   (input valid, found, blob_index, output ready);
endinterface

>>> rtl/core/point_in_polygon_blob_finder.sv
// Point-in-polygon blob finder: vertex memory, query sequencer and result register.
//
// Usage: items arrive on in_i (valid/ready). kind = load writes one vertex
// (coord_x, coord_y) of polygon blob_slot at vertex_slot; last_vertex sets the
// polygon's vertex count to vertex_slot + 1. A load gives
// no result. kind = query tests point (coord_x, coord_y) against polygons
// 0 .. blobs_in_use-1 by the even-odd rule and returns one item on out_o:
// found and the first containing blob_index (0 when not found).
// A query walks one edge per cycle through the single vertex memory read
// port: each non-empty searched blob is primed with its last vertex, walked
// and drained, empty blobs are skipped, and the search stops at the first hit.
// One item is in work at a time; in_i.ready is high only while idle.
// The result sits in an output register; if the receiver stalls, a later
// query finishes its search and waits for that register to empty.
// blobs_in_use is written through cfg_we_i / cfg_wdata_i; the user must write
// it only while idle, as the block itself does not enforce this.
// Reset clears the vertex counts, the register and the control state;
// vertex memory contents stay undefined until loaded, and no clearing pass runs.
module point_in_polygon_blob_finder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pip_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  pip_in_if.sink                        in_i,
  pip_out_if.source                     out_o
);

  pip_pkg::pip_state_e state_q, state_d;

  logic [pip_pkg::CFG_BITS-1:0]        cfg_q;
  logic [pip_pkg::CNT_BITS-1:0]        vcount_q [pip_pkg::MAX_BLOBS];

  logic [2*pip_pkg::COORD_BITS-1:0]    mem_q [pip_pkg::VTX_DEPTH];
  logic [2*pip_pkg::COORD_BITS-1:0]    rd_data_q;
  logic                                rd_valid_q, rd_prime_q;

  logic [pip_pkg::BLOB_CNT_BITS-1:0]   blob_q;
  logic [pip_pkg::VERT_BITS-1:0]       vi_q;
  logic signed [pip_pkg::COORD_BITS-1:0] px_q, py_q;
  logic                                found_q;

  logic                                out_valid_q, out_found_q;
  logic [pip_pkg::SLOT_BLOB_BITS-1:0]  out_idx_q;

  logic                                in_fire, load_fire, query_fire, load_ok;
  logic [pip_pkg::ADDR_BITS-1:0]       wr_addr, rd_addr, base_addr;
  logic [pip_pkg::BLOB_IDX_BITS-1:0]   blob_idx;
  logic [pip_pkg::CNT_BITS-1:0]        cur_count;
  logic [pip_pkg::VERT_BITS-1:0]       last_vi, rd_vi;
  logic                                search_done, blob_empty, walk_end, drain_done;
  logic                                slot_free;

  logic                                rd_issue, rd_prime, out_load;
  pip_pkg::pip_edge_ctl_t              edge_ctl;
  pip_pkg::pip_edge_sts_t              edge_sts;

  assign in_fire    = in_i.valid && in_i.ready;
  assign load_fire  = in_fire && (in_i.kind == pip_pkg::KIND_LOAD);
  assign query_fire = in_fire && (in_i.kind == pip_pkg::KIND_QUERY);
  assign load_ok    = (32'(in_i.blob_slot) < pip_pkg::MAX_BLOBS) &&
                      (32'(in_i.vertex_slot) < pip_pkg::MAX_VERTS);
  assign wr_addr    = pip_pkg::ADDR_BITS'(in_i.blob_slot) *
                      pip_pkg::ADDR_BITS'(pip_pkg::MAX_VERTS) +
                      pip_pkg::ADDR_BITS'(in_i.vertex_slot);

  // Searching stops at blobs_in_use, capped at the number of slots.
  assign search_done = (32'(blob_q) >= 32'(cfg_q)) ||
                       (32'(blob_q) >= pip_pkg::MAX_BLOBS);
  assign blob_idx    = blob_q[pip_pkg::BLOB_IDX_BITS-1:0];
  assign cur_count   = vcount_q[blob_idx];
  assign blob_empty  = (cur_count == '0);
  assign last_vi     = pip_pkg::VERT_BITS'(cur_count - 1'b1);
  assign walk_end    = (vi_q == last_vi);
  assign drain_done  = !rd_valid_q && !edge_sts.busy;
  assign slot_free   = !out_valid_q || out_o.ready;

  assign base_addr = pip_pkg::ADDR_BITS'(blob_idx) * pip_pkg::ADDR_BITS'(pip_pkg::MAX_VERTS);
  assign rd_vi     = rd_prime ? last_vi : vi_q;
  assign rd_addr   = base_addr + pip_pkg::ADDR_BITS'(rd_vi);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pip_pkg::ST_IDLE: begin
        if (query_fire) state_d = pip_pkg::ST_NEXT;
      end
      pip_pkg::ST_NEXT: begin
        if (search_done) state_d = pip_pkg::ST_FINISH;
        else if (!blob_empty) state_d = pip_pkg::ST_PRIME;
      end
      pip_pkg::ST_PRIME: state_d = pip_pkg::ST_WALK;
      pip_pkg::ST_WALK: begin
        if (walk_end) state_d = pip_pkg::ST_DRAIN;
      end
      pip_pkg::ST_DRAIN: begin
        if (drain_done) begin
          state_d = edge_sts.hit ? pip_pkg::ST_FINISH : pip_pkg::ST_NEXT;
        end
      end
      pip_pkg::ST_FINISH: begin
        if (slot_free) state_d = pip_pkg::ST_IDLE;
      end
      default: state_d = pip_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_i.ready          = 1'b0;
    rd_issue            = 1'b0;
    rd_prime            = 1'b0;
    out_load            = 1'b0;
    edge_ctl.clear      = 1'b0;
    edge_ctl.data_valid = rd_valid_q;
    edge_ctl.prime      = rd_prime_q;
    case (state_q)
      pip_pkg::ST_IDLE:  in_i.ready = 1'b1;
      pip_pkg::ST_NEXT:  edge_ctl.clear = 1'b1;
      pip_pkg::ST_PRIME: begin
        rd_issue = 1'b1;
        rd_prime = 1'b1;
      end
      pip_pkg::ST_WALK:   rd_issue = 1'b1;
      pip_pkg::ST_DRAIN:  ;
      pip_pkg::ST_FINISH: out_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pip_pkg::ST_IDLE;
      cfg_q       <= '0;
      rd_valid_q  <= 1'b0;
      rd_prime_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < pip_pkg::MAX_BLOBS; b++) vcount_q[b] <= '0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_issue;
      rd_prime_q <= rd_prime;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (load_fire && load_ok && in_i.last_vertex) begin
        vcount_q[in_i.blob_slot[pip_pkg::BLOB_IDX_BITS-1:0]] <=
          pip_pkg::CNT_BITS'(in_i.vertex_slot) + 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Vertex memory: x in the upper half, y in the lower half.
  always_ff @(posedge clk_i) begin
    if (load_fire && load_ok) mem_q[wr_addr] <= {in_i.coord_x, in_i.coord_y};
    if (rd_issue) rd_data_q <= mem_q[rd_addr];
  end

  // Query datapath.
  always_ff @(posedge clk_i) begin
    if (query_fire) begin
      px_q    <= in_i.coord_x;
      py_q    <= in_i.coord_y;
      blob_q  <= '0;
      found_q <= 1'b0;
    end
    if (state_q == pip_pkg::ST_NEXT && !search_done) begin
      if (blob_empty) blob_q <= blob_q + 1'b1;
      else vi_q <= '0;
    end
    if (state_q == pip_pkg::ST_WALK) vi_q <= vi_q + 1'b1;
    if (state_q == pip_pkg::ST_DRAIN && drain_done) begin
      if (edge_sts.hit) found_q <= 1'b1;
      else blob_q <= blob_q + 1'b1;
    end
    if (out_load) begin
      out_found_q <= found_q;
      out_idx_q   <= found_q ? pip_pkg::SLOT_BLOB_BITS'(blob_q) : '0;
    end
  end

  pip_edge_pipe u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (edge_ctl),
    .vtx_x_i (rd_data_q[2*pip_pkg::COORD_BITS-1:pip_pkg::COORD_BITS]),
    .vtx_y_i (rd_data_q[pip_pkg::COORD_BITS-1:0]),
    .pt_x_i  (px_q),
    .pt_y_i  (py_q),
    .sts_o   (edge_sts)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.found      = out_found_q;
  assign out_o.blob_index = out_idx_q;

endmodule

>>> rtl/core/pip_edge_pipe.sv
// Edge crossing pipeline: differences, cross products, compare and parity toggle.
module pip_edge_pipe (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pip_pkg::pip_edge_ctl_t                ctl_i,
  input  logic signed [pip_pkg::COORD_BITS-1:0] vtx_x_i,
  input  logic signed [pip_pkg::COORD_BITS-1:0] vtx_y_i,
  input  logic signed [pip_pkg::COORD_BITS-1:0] pt_x_i,
  input  logic signed [pip_pkg::COORD_BITS-1:0] pt_y_i,
  output pip_pkg::pip_edge_sts_t                sts_o
);

  logic signed [pip_pkg::COORD_BITS-1:0] prev_x_q, prev_y_q;

  logic                                  straddle;
  logic signed [pip_pkg::DIFF_BITS-1:0]  dy_d, dxp_d, dxe_d, dyp_d;

  logic                                  s1_v_q;
  logic                                  s1_dy_pos_q;
  logic signed [pip_pkg::DIFF_BITS-1:0]  s1_dy_q, s1_dxp_q, s1_dxe_q, s1_dyp_q;

  logic                                  s2_v_q;
  logic                                  s2_dy_pos_q;
  logic signed [pip_pkg::PROD_BITS-1:0]  s2_lhs_q, s2_rhs_q;
  logic signed [pip_pkg::PROD_BITS-1:0]  lhs_d, rhs_d;

  logic                                  left;
  logic                                  inside_q;

  // Current vertex i comes from memory, previous vertex j is held here.
  assign straddle = ((vtx_y_i <= pt_y_i) && (pt_y_i < prev_y_q)) ||
                    ((prev_y_q <= pt_y_i) && (pt_y_i < vtx_y_i));
  assign dy_d  = pip_pkg::DIFF_BITS'(prev_y_q) - pip_pkg::DIFF_BITS'(vtx_y_i);
  assign dxp_d = pip_pkg::DIFF_BITS'(pt_x_i)   - pip_pkg::DIFF_BITS'(vtx_x_i);
  assign dxe_d = pip_pkg::DIFF_BITS'(prev_x_q) - pip_pkg::DIFF_BITS'(vtx_x_i);
  assign dyp_d = pip_pkg::DIFF_BITS'(pt_y_i)   - pip_pkg::DIFF_BITS'(vtx_y_i);

  assign lhs_d = pip_pkg::PROD_BITS'(s1_dxp_q) * pip_pkg::PROD_BITS'(s1_dy_q);
  assign rhs_d = pip_pkg::PROD_BITS'(s1_dxe_q) * pip_pkg::PROD_BITS'(s1_dyp_q);

  assign left = s2_dy_pos_q ? (s2_lhs_q < s2_rhs_q) : (s2_lhs_q > s2_rhs_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.data_valid) begin
      prev_x_q <= vtx_x_i;
      prev_y_q <= vtx_y_i;
    end
    s1_dy_q     <= dy_d;
    s1_dxp_q    <= dxp_d;
    s1_dxe_q    <= dxe_d;
    s1_dyp_q    <= dyp_d;
    s1_dy_pos_q <= (dy_d > 0);
    s2_lhs_q    <= lhs_d;
    s2_rhs_q    <= rhs_d;
    s2_dy_pos_q <= s1_dy_pos_q;
  end

  // Only straddling edges travel on; the rest can never toggle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      s1_v_q <= ctl_i.data_valid && !ctl_i.prime && straddle;
      s2_v_q <= s1_v_q;
      if (ctl_i.clear) begin
        inside_q <= 1'b0;
      end else if (s2_v_q && left) begin
        inside_q <= !inside_q;
      end
    end
  end

  assign sts_o.busy = s1_v_q || s2_v_q;
  assign sts_o.hit  = inside_q;

endmodule

>>> rtl/core/pip_checker.sv
// Port-level checker for the point-in-polygon blob finder, bound to the top level.
`include "point_in_polygon_blob_finder_defines.svh"

module pip_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               in_kind_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic                               out_found_i,
  input logic [pip_pkg::SLOT_BLOB_BITS-1:0] out_blob_index_i
);

  logic query_fire, new_result, pend_q, out_hold_q;

  assign query_fire = in_valid_i && in_ready_i && (in_kind_i == pip_pkg::KIND_QUERY);
  // A result is new unless it was left waiting at the last edge.
  assign new_result = out_valid_i && !out_hold_q;

  // Tracks a query whose result has not yet been presented.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      out_hold_q <= 1'b0;
    end else begin
      out_hold_q <= out_valid_i && !out_ready_i;
      if (query_fire) begin
        pend_q <= 1'b1;
      end else if (new_result) begin
        pend_q <= 1'b0;
      end
    end
  end

  `PIP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `PIP_ASSERT_NOW(a_miss_index, clk_i, rst_ni, out_valid_i && !out_found_i, out_blob_index_i == '0, "blob index not zero on a miss")
  `PIP_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, query_fire, !in_ready_i, "item taken during a search")
  `PIP_ASSERT_NOW(a_result_owed, clk_i, rst_ni, new_result, pend_q, "result without a query")

endmodule

bind point_in_polygon_blob_finder pip_checker u_pip_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_kind_i        (in_i.kind),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_found_i      (out_o.found),
  .out_blob_index_i (out_o.blob_index)
);
